// ----- hdl/plfc_pkg.sv -----
package plfc_pkg;

  localparam int unsigned NUM_PHASES = 3;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned BP_W       = 31;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = 3;

  // magnitude of a current step, shifted up by 16 fraction bits
  localparam int unsigned NUM_W      = 48;
  localparam int unsigned CNT_W      = 6;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_MULT,
    ST_OFFSET,
    ST_NEXT,
    ST_OUTPUT
  } plfc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic setup;
    logic div_start;
    logic div_step;
    logic mult;
    logic offset;
    logic [1:0] phase;
    logic finish;
  } plfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } plfc_sts_t;

endpackage

// ----- hdl/piecewise_linear_flux_to_current_model.sv -----
// each item runs one phase per flux; each phase runs setup, 48 restoring divide
// steps, a done check, multiply, offset and a next state, the last of which also
// compares and stores
// a new beat is taken only while idle, so not before the result beat is taken;
// the next beat can be taken in the cycle after the result beat
// reset: rst_n synchronous active low; breakpoints to defaults, stored values to zero
module piecewise_linear_flux_to_current_model
  import plfc_pkg::*;
#(
  parameter int unsigned SEGMENTS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // flux_a, flux_b, flux_c
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [199:0]  out_tdata,  // slope_a..c, offset_a..c, changed, zero pad
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  plfc_cmd_t cmd;
  plfc_sts_t sts;
  logic busy;
  logic [6*DATA_W:0] result;

  assign in_tready = !busy;
  assign cfg_ready = 1'b1;

  plfc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready),
    .out_fire(out_tvalid && out_tready),
    .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_tvalid)
  );

  plfc_datapath #(.SEGMENTS(SEGMENTS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .item_in(in_tdata), .cmd(cmd), .sts(sts), .result(result)
  );

  assign out_tdata = {7'd0, result};

endmodule

// ----- hdl/plfc_datapath.sv -----
module plfc_datapath
  import plfc_pkg::*;
#(
  parameter int unsigned SEGMENTS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_idx,
  input  logic [DATA_W-1:0]        cfg_val,
  input  logic [3*DATA_W-1:0]      item_in,
  input  plfc_cmd_t                cmd,
  output plfc_sts_t                sts,
  output logic [6*DATA_W:0]        result
);

  localparam int unsigned SEG_N = (SEGMENTS < 1) ? 1 : ((SEGMENTS > 4) ? 4 : SEGMENTS);

  // breakpoint registers, index 0 is the implicit origin
  logic [BP_W-1:0] flux_bp_r [5];
  logic [BP_W-1:0] cur_bp_r  [5];
  logic [3*DATA_W-1:0] item_r;
  logic signed [DATA_W-1:0] slope_r  [NUM_PHASES];
  logic signed [DATA_W-1:0] offset_r [NUM_PHASES];
  logic signed [DATA_W-1:0] st_slope_r  [NUM_PHASES];
  logic signed [DATA_W-1:0] st_offset_r [NUM_PHASES];
  logic changed_r;

  // per-phase working registers
  logic             neg_r;
  logic [BP_W-1:0]  fs_r;
  logic [BP_W-1:0]  is_r;
  logic             zero_df_r;
  logic signed [2:0] di_sgn_r;
  logic             qneg_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] rem_r;
  logic [BP_W:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [63:0] prod_r;

  // breakpoint writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flux_bp_r[0] <= '0; flux_bp_r[1] <= 31'd65536; flux_bp_r[2] <= 31'd131072;
      flux_bp_r[3] <= 31'd196608; flux_bp_r[4] <= 31'd262144;
      cur_bp_r[0] <= '0; cur_bp_r[1] <= 31'd65536; cur_bp_r[2] <= 31'd655360;
      cur_bp_r[3] <= 31'd1966080; cur_bp_r[4] <= 31'd3932160;
    end else if (cfg_we) begin
      if (!cfg_idx[2]) flux_bp_r[{1'b0, cfg_idx[1:0]} + 3'd1] <= cfg_val[BP_W-1:0];
      else cur_bp_r[{1'b0, cfg_idx[1:0]} + 3'd1] <= cfg_val[BP_W-1:0];
    end
  end

  // segment search for the current phase
  logic [DATA_W-1:0] flux_bits;
  logic              flux_neg;
  logic [DATA_W-1:0] flux_mag;
  logic [2:0]        seg;
  always_comb begin
    flux_bits = item_r[cmd.phase*DATA_W +: DATA_W];
    flux_neg  = flux_bits[DATA_W-1];
    flux_mag  = flux_neg ? (~flux_bits + 32'd1) : flux_bits;
    seg = 3'(SEG_N - 1);
    for (int k = SEG_N - 1; k >= 0; k--) begin
      if (flux_mag <= {1'b0, flux_bp_r[k+1]}) seg = 3'(k);
    end
  end

  logic signed [BP_W:0] df_s, di_s;
  assign df_s = $signed({1'b0, flux_bp_r[seg + 3'd1]}) - $signed({1'b0, flux_bp_r[seg]});
  assign di_s = $signed({1'b0, cur_bp_r[seg + 3'd1]}) - $signed({1'b0, cur_bp_r[seg]});

  logic [BP_W:0] di_abs, df_abs;
  assign di_abs = di_s[BP_W] ? (~di_s + 1'b1) : di_s;
  assign df_abs = df_s[BP_W] ? (~df_s + 1'b1) : df_s;

  // restoring divide step
  logic [NUM_W-1:0] rem_sh;
  logic [NUM_W:0]   trial;
  assign rem_sh = {rem_r[NUM_W-2:0], num_r[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {{(NUM_W-BP_W){1'b0}}, den_r};

  // slope from quotient, saturated
  logic signed [DATA_W-1:0] slope_sel;
  always_comb begin
    if (zero_df_r) begin
      slope_sel = (di_sgn_r > 0) ? SAT_MAX : ((di_sgn_r < 0) ? SAT_MIN : '0);
    end else if (!qneg_r) begin
      slope_sel = (num_r > NUM_W'(SAT_MAX)) ? SAT_MAX : DATA_W'(num_r);
    end else begin
      slope_sel = (num_r >= NUM_W'(33'h80000000)) ? SAT_MIN : -$signed(DATA_W'(num_r));
    end
  end

  // offset from registered product
  logic signed [64:0] icpt, icpt_s;
  logic signed [DATA_W-1:0] offset_sel;
  always_comb begin
    icpt   = $signed({34'd0, is_r}) - 65'(prod_r >>> 16);
    icpt_s = neg_r ? -icpt : icpt;
    if (icpt_s > 65'sd2147483647)       offset_sel = SAT_MAX;
    else if (icpt_s < -65'sd2147483648) offset_sel = SAT_MIN;
    else                                offset_sel = icpt_s[DATA_W-1:0];
  end

  logic diff;
  always_comb begin
    diff = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++)
      if (slope_r[p] != st_slope_r[p] || offset_r[p] != st_offset_r[p]) diff = 1'b1;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
        st_slope_r[p]  <= '0;
        st_offset_r[p] <= '0;
      end
    end else begin
      if (cmd.load_item) item_r <= item_in;
      if (cmd.setup) begin
        neg_r     <= flux_neg;
        fs_r      <= flux_bp_r[seg];
        is_r      <= cur_bp_r[seg];
        zero_df_r <= (df_s == '0);
        di_sgn_r  <= (di_s == '0) ? 3'sd0 : (di_s[BP_W] ? -3'sd1 : 3'sd1);
        qneg_r    <= di_s[BP_W] ^ df_s[BP_W];
        num_r     <= {di_abs[BP_W-1:0], 16'd0} | NUM_W'(di_abs[BP_W]) << 47;
        den_r     <= df_abs;
      end
      if (cmd.div_start) begin
        rem_r <= '0;
        cnt_r <= CNT_W'(NUM_W);
      end
      if (cmd.div_step) begin
        if (!trial[NUM_W]) begin
          rem_r <= trial[NUM_W-1:0];
          num_r <= {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          num_r <= {num_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.mult) begin
        slope_r[cmd.phase] <= slope_sel;
        prod_r <= slope_sel * $signed({1'b0, fs_r});
      end
      if (cmd.offset) offset_r[cmd.phase] <= offset_sel;
      if (cmd.finish) begin
        changed_r <= diff;
        if (diff) begin
          for (int p = 0; p < NUM_PHASES; p++) begin
            st_slope_r[p]  <= slope_r[p];
            st_offset_r[p] <= offset_r[p];
          end
        end
      end
    end
  end

  assign sts.div_done = (cnt_r == '0);
  assign result = {changed_r, offset_r[2], offset_r[1], offset_r[0],
                   slope_r[2], slope_r[1], slope_r[0]};

endmodule

// ----- hdl/plfc_ctrl.sv -----
module plfc_ctrl
  import plfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_fire,
  input  plfc_sts_t sts,
  output plfc_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  plfc_state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd = '0;
    cmd.phase = phase_r;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load_item = 1'b1;
          phase_nxt = '0;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.div_done) state_nxt = ST_MULT;
        else cmd.div_step = 1'b1;
      end
      ST_MULT: begin
        cmd.mult = 1'b1;
        state_nxt = ST_OFFSET;
      end
      ST_OFFSET: begin
        cmd.offset = 1'b1;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (phase_r == 2'd2) begin
          cmd.finish = 1'b1;
          state_nxt = ST_OUTPUT;
        end else begin
          phase_nxt = phase_r + 2'd1;
          state_nxt = ST_SETUP;
        end
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/plfc_checker.sv -----
module plfc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata
);

  // no new beat taken while a result waits
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during output");

  // a result does not follow an input in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[199:193] == 7'd0) else $error("pad bits set");

endmodule

bind piecewise_linear_flux_to_current_model plfc_checker u_plfc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ----- tb/plfc_monitor.sv -----
`timescale 1ns / 100ps

module plfc_monitor
  import plfc_pkg::*;
#(
  parameter int unsigned SEGMENTS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [95:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [199:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           mismatches,
  output int           pending
);

  typedef struct packed {
    logic        changed;
    logic [31:0] offset_c;
    logic [31:0] offset_b;
    logic [31:0] offset_a;
    logic [31:0] slope_c;
    logic [31:0] slope_b;
    logic [31:0] slope_a;
  } curve_result_t;

  logic [BP_W-1:0]   flux_pt [5];
  logic [BP_W-1:0]   cur_pt  [5];
  logic [DATA_W-1:0] last_slope  [NUM_PHASES];
  logic [DATA_W-1:0] last_offset [NUM_PHASES];
  curve_result_t     expected_results [$];

  function automatic longint clip32(longint v);
    if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
    if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
    return v;
  endfunction

  // segment lookup, slope and signed intercept for one phase
  function automatic void curve_phase(input logic [31:0] flux,
                                      output logic [31:0] slope_o,
                                      output logic [31:0] offset_o);
    logic neg;
    longint unsigned mag, ni, nf, q;
    longint df, di, slope, prod, icpt;
    int seg, nseg;
    bit found;
    neg = flux[31];
    mag = neg ? longint'({32'd0, ~flux}) + 1 : longint'({32'd0, flux});
    nseg = (SEGMENTS < 1) ? 1 : ((SEGMENTS > 4) ? 4 : SEGMENTS);
    seg = nseg - 1;
    found = 0;
    for (int k = 0; k < 4; k++) begin
      if (!found && k < nseg && mag <= longint'({33'd0, flux_pt[k+1]})) begin
        seg = k;
        found = 1;
      end
    end
    df = longint'({33'd0, flux_pt[seg+1]}) - longint'({33'd0, flux_pt[seg]});
    di = longint'({33'd0, cur_pt[seg+1]}) - longint'({33'd0, cur_pt[seg]});
    if (df == 0) begin
      slope = (di > 0) ? longint'(SAT_MAX) : ((di < 0) ? longint'(SAT_MIN) : 0);
    end else begin
      ni = longint'(di < 0 ? -di : di) << 16;
      nf = longint'(df < 0 ? -df : df);
      q = ni / nf;
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      slope = clip32(((di < 0) != (df < 0)) ? -longint'(q) : longint'(q));
    end
    prod = slope * longint'({33'd0, flux_pt[seg]});
    icpt = longint'({33'd0, cur_pt[seg]}) - (prod >>> 16);
    if (neg) icpt = -icpt;
    icpt = clip32(icpt);
    slope_o = slope[31:0];
    offset_o = icpt[31:0];
  endfunction

  always @(posedge clk) begin
    curve_result_t exp_r, got;
    logic [31:0] sl [3];
    logic [31:0] of [3];
    logic chg;
    if (!rst_n) begin
      flux_pt[0] = '0; flux_pt[1] = 31'd65536; flux_pt[2] = 31'd131072;
      flux_pt[3] = 31'd196608; flux_pt[4] = 31'd262144;
      cur_pt[0] = '0; cur_pt[1] = 31'd65536; cur_pt[2] = 31'd655360;
      cur_pt[3] = 31'd1966080; cur_pt[4] = 31'd3932160;
      for (int p = 0; p < 3; p++) begin
        last_slope[p] = '0;
        last_offset[p] = '0;
      end
      expected_results.delete();
      mismatches = 0;
      pending = 0;
    end else begin
      // register write beat
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < 4) flux_pt[cfg_index + 1] = cfg_data[30:0];
        else cur_pt[cfg_index - 3] = cfg_data[30:0];
      end
      // input beat: predict and store
      if (in_tvalid && in_tready) begin
        chg = 0;
        for (int p = 0; p < 3; p++) begin
          curve_phase(in_tdata[p*32 +: 32], sl[p], of[p]);
          if (sl[p] != last_slope[p] || of[p] != last_offset[p]) chg = 1;
        end
        if (chg) begin
          for (int p = 0; p < 3; p++) begin
            last_slope[p] = sl[p];
            last_offset[p] = of[p];
          end
        end
        expected_results.push_back({chg, of[2], of[1], of[0], sl[2], sl[1], sl[0]});
      end
      // result beat: compare with oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata[192:0];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: slopes exp %h %h %h got %h %h %h,",
                       exp_r.slope_a, exp_r.slope_b, exp_r.slope_c,
                       got.slope_a, got.slope_b, got.slope_c,
                       " offsets exp %h %h %h got %h %h %h,",
                       exp_r.offset_a, exp_r.offset_b, exp_r.offset_c,
                       got.offset_a, got.offset_b, got.offset_c,
                       " changed exp %b got %b",
                       exp_r.changed, got.changed);
          end
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import plfc_pkg::*;

  localparam int unsigned SEGMENTS = 4;

  typedef enum int {
    REG_FLUX_ONE, REG_FLUX_TWO, REG_FLUX_THREE, REG_FLUX_FOUR,
    REG_CUR_ONE, REG_CUR_TWO, REG_CUR_THREE, REG_CUR_FOUR
  } reg_index_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // flux_a, flux_b, flux_c
  logic         out_tvalid;
  logic         out_tready;
  logic [199:0] out_tdata;  // slope_a..c, offset_a..c, changed, zero pad
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           mismatches;
  int           pending;

  bit           quiet;
  int           stall_left;
  logic [30:0]  flux_copy [4];
  logic [95:0]  prev_item;

  piecewise_linear_flux_to_current_model #(.SEGMENTS(SEGMENTS)) dut (.*);

  plfc_monitor #(.SEGMENTS(SEGMENTS)) monitor (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver stalls in random bursts
  initial begin
    out_tready = 1;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_flux(input logic [31:0] a, b, c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {c, b, a};
    prev_item = {c, b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  // wait for the block to drain before touching registers
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx[2:0];
    cfg_data <= val;
    if (idx < REG_CUR_ONE) flux_copy[idx] = val[30:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_curve(input logic [31:0] f1, f2, f3, f4, c1, c2, c3, c4,
                            input bit upper_junk);
    logic [31:0] junk;
    junk = upper_junk ? 32'h8000_0000 : 32'd0;
    drain();
    write_reg(REG_FLUX_ONE, f1 | junk);
    write_reg(REG_FLUX_TWO, f2);
    write_reg(REG_FLUX_THREE, f3 | junk);
    write_reg(REG_FLUX_FOUR, f4);
    write_reg(REG_CUR_ONE, c1);
    write_reg(REG_CUR_TWO, c2 | junk);
    write_reg(REG_CUR_THREE, c3);
    write_reg(REG_CUR_FOUR, c4 | junk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_flux();
    logic [31:0] m;
    case ($urandom_range(0, 3))
      0: m = $urandom;
      1: m = {1'b0, flux_copy[$urandom_range(0, 3)]} + $urandom_range(0, 4) - 2;
      2: m = $urandom_range(0, {1'b0, flux_copy[3]} + ({1'b0, flux_copy[3]} >> 3));
      default: m = $urandom_range(0, 65536);
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic random_items(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_flux(prev_item[31:0], prev_item[63:32], prev_item[95:64]);
      else
        send_flux(pick_flux(), pick_flux(), pick_flux());
    end
  endtask

  task automatic random_curve();
    logic [31:0] f [4];
    logic [31:0] c [4];
    f[0] = $urandom_range(1, 200000);
    c[0] = $urandom_range(1, 2000000);
    for (int k = 1; k < 4; k++) begin
      f[k] = f[k-1] + $urandom_range(1, 300000);
      c[k] = c[k-1] + $urandom_range(0, 5000000);
    end
    load_curve(f[0], f[1], f[2], f[3], c[0], c[1], c[2], c[3], $urandom_range(0, 1));
  endtask

  initial begin
    rst_n = 0;
    quiet = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    prev_item = '0;
    flux_copy[0] = 31'd65536; flux_copy[1] = 31'd131072;
    flux_copy[2] = 31'd196608; flux_copy[3] = 31'd262144;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero, unit, extremes, breakpoints and either side of them
    send_flux(32'd0, 32'd0, 32'd0);
    send_flux(32'd0, 32'd0, 32'd0);
    send_flux(32'd1, -32'd1, 32'd65535);
    send_flux(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001);
    send_flux(32'd65536, 32'd65537, -32'd65536);
    send_flux(32'd131072, -32'd131073, 32'd196608);
    send_flux(32'd196609, 32'd262144, -32'd262145);
    send_flux(-32'd262144, 32'd300000, 32'hffff_0000);
    send_flux(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);
    send_flux(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);

    // all breakpoints at top: zero flux steps, flat and rising
    load_curve(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
    send_flux(32'd0, 32'h7fff_ffff, 32'h8000_0000);
    send_flux(32'd5, -32'd5, 32'h8000_0001);
    random_items(150);

    // all at minimum, then falling currents over steep flux steps
    load_curve(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 0);
    send_flux(32'd0, 32'd1, 32'd2);
    random_items(100);
    load_curve(32'd1, 32'd2, 32'd3, 32'd4,
               32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1, 0);
    send_flux(32'd1, -32'd2, 32'd3);
    send_flux(32'd4, -32'd5, 32'h8000_0000);
    random_items(150);

    // non-increasing breakpoints
    load_curve(32'h7000_0000, 32'h0100_0000, 32'h4000_0000, 32'h0000_1000,
               32'd1000, 32'h6000_0000, 32'd5, 32'h7fff_ffff, 1);
    random_items(200);

    for (int ph = 0; ph < 4; ph++) begin
      random_curve();
      random_items(220);
    end

    // back to the defaults, last part without idling
    load_curve(32'd65536, 32'd131072, 32'd196608, 32'd262144,
               32'd65536, 32'd655360, 32'd1966080, 32'd3932160, 0);
    quiet = 1;
    random_items(250);
    in_tvalid <= 0;
    @(posedge clk);

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
